>>> rtl/core/rbmj_pkg.sv
// Shared widths, constants and the arctangent table of the range-bearing measurement block.
package rbmj_pkg;

   // Field widths of the request and response items.
   localparam int COORD_FIELD_W  = 16;
   localparam int COORD_BITS_DEF = 16;
   localparam int ANGLE_W        = 16;
   localparam int RANGE_W        = 17;
   localparam int RGRAD_W        = 16;
   localparam int BGRAD_W        = 32;

   // Fraction bits of the two gradient rows.
   localparam int RGRAD_FRAC = 14;
   localparam int BGRAD_FRAC = 30;

   // CORDIC datapath: normalized inputs sit in [2^30, 2^31), angles use pi = 2^31.
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_W     = 35;
   localparam int ANG_ACC_W    = 32;
   localparam int NORM_W       = 31;

   localparam logic [ANG_ACC_W-1:0] ANGLE_PI   = 32'h8000_0000;
   localparam logic [ANG_ACC_W-1:0] ANGLE_HALF = 32'h0000_8000;

   // Arctangent of 2^-step in units of pi = 2^31.
   function automatic logic [ANG_ACC_W-1:0] cordic_atan(input int step);
      logic [ANG_ACC_W-1:0] val;
      case (step)
         0:  val = 32'h2000_0000;
         1:  val = 32'h12E4_051E;
         2:  val = 32'h09FB_385B;
         3:  val = 32'h0511_11D4;
         4:  val = 32'h028B_0D43;
         5:  val = 32'h0145_D7E1;
         6:  val = 32'h00A2_F61E;
         7:  val = 32'h0051_7C55;
         8:  val = 32'h0028_BE53;
         9:  val = 32'h0014_5F2F;
         10: val = 32'h000A_2F98;
         11: val = 32'h0005_17CC;
         12: val = 32'h0002_8BE6;
         13: val = 32'h0001_45F3;
         14: val = 32'h0000_A2FA;
         15: val = 32'h0000_517D;
         16: val = 32'h0000_28BE;
         17: val = 32'h0000_145F;
         18: val = 32'h0000_0A30;
         19: val = 32'h0000_0518;
         20: val = 32'h0000_028C;
         21: val = 32'h0000_0146;
         22: val = 32'h0000_00A3;
         23: val = 32'h0000_0051;
         24: val = 32'h0000_0029;
         25: val = 32'h0000_0014;
         26: val = 32'h0000_000A;
         27: val = 32'h0000_0005;
         28: val = 32'h0000_0003;
         29: val = 32'h0000_0001;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> rtl/core/rbmj_if.sv
// Request and response channel interfaces of the range-bearing measurement block.
interface rbmj_req_if;
   logic                                             valid;
   logic                                             ready;
   logic signed [rbmj_pkg::COORD_FIELD_W-1:0]        landmark_x;
   logic signed [rbmj_pkg::COORD_FIELD_W-1:0]        landmark_y;
   logic signed [rbmj_pkg::COORD_FIELD_W-1:0]        particle_x;
   logic signed [rbmj_pkg::COORD_FIELD_W-1:0]        particle_y;
   logic signed [rbmj_pkg::ANGLE_W-1:0]              particle_heading;

   modport source (output valid, landmark_x, landmark_y, particle_x, particle_y,
                   particle_heading, input ready);
   modport sink   (input valid, landmark_x, landmark_y, particle_x, particle_y,
                   particle_heading, output ready);
endinterface

interface rbmj_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic        [rbmj_pkg::RANGE_W-1:0]  expected_range;
   logic signed [rbmj_pkg::ANGLE_W-1:0]  expected_bearing;
   logic signed [rbmj_pkg::RGRAD_W-1:0]  range_grad_x;
   logic signed [rbmj_pkg::RGRAD_W-1:0]  range_grad_y;
   logic signed [rbmj_pkg::BGRAD_W-1:0]  bearing_grad_x;
   logic signed [rbmj_pkg::BGRAD_W-1:0]  bearing_grad_y;
   logic                                 zero_range;

   modport source (output valid, expected_range, expected_bearing, range_grad_x,
                   range_grad_y, bearing_grad_x, bearing_grad_y, zero_range, input ready);
   modport sink   (input valid, expected_range, expected_bearing, range_grad_x,
                   range_grad_y, bearing_grad_x, bearing_grad_y, zero_range, output ready);
endinterface

>>> rtl/core/rbmj_cordic_step.sv
// One vectoring-mode CORDIC rotation of the bearing pipeline.
module rbmj_cordic_step #(
   parameter int STEP = 0
) (
   input  logic signed [rbmj_pkg::CORDIC_W-1:0]  x_i,
   input  logic signed [rbmj_pkg::CORDIC_W-1:0]  y_i,
   input  logic        [rbmj_pkg::ANG_ACC_W-1:0] z_i,
   output logic signed [rbmj_pkg::CORDIC_W-1:0]  x_o,
   output logic signed [rbmj_pkg::CORDIC_W-1:0]  y_o,
   output logic        [rbmj_pkg::ANG_ACC_W-1:0] z_o
);

   localparam logic [rbmj_pkg::ANG_ACC_W-1:0] ATAN = rbmj_pkg::cordic_atan(STEP);

   logic signed [rbmj_pkg::CORDIC_W-1:0] x_sh;
   logic signed [rbmj_pkg::CORDIC_W-1:0] y_sh;

   // Shifts truncate toward zero; x never goes negative.
   always_comb begin
      x_sh = x_i >>> STEP;
      if (y_i[rbmj_pkg::CORDIC_W-1]) begin
         y_sh = -((-y_i) >>> STEP);
      end else begin
         y_sh = y_i >>> STEP;
      end
   end

   // Rotate toward the x axis and accumulate the angle.
   always_comb begin
      if (!y_i[rbmj_pkg::CORDIC_W-1]) begin
         x_o = x_i + y_sh;
         y_o = y_i - x_sh;
         z_o = z_i + ATAN;
      end else begin
         x_o = x_i - y_sh;
         y_o = y_i + x_sh;
         z_o = z_i - ATAN;
      end
   end

endmodule

>>> rtl/core/rbmj_sqrt_step.sv
// One digit of the restoring integer square root.
module rbmj_sqrt_step #(
   parameter int ROOT_W = 17
) (
   input  logic [ROOT_W:0]   rem_i,
   input  logic [ROOT_W-1:0] root_i,
   input  logic [1:0]        pair_i,
   output logic [ROOT_W:0]   rem_o,
   output logic [ROOT_W-1:0] root_o
);

   logic [ROOT_W+2:0] cur;
   logic [ROOT_W+2:0] trial;
   logic              fits;

   // Bring down the next radicand pair and try the next root bit.
   always_comb begin
      cur   = {rem_i, pair_i};
      trial = {1'b0, root_i, 2'b01};
      fits  = (cur >= trial);
      if (fits) begin
         rem_o = (ROOT_W+1)'(cur - trial);
      end else begin
         rem_o = (ROOT_W+1)'(cur);
      end
      root_o = {root_i[ROOT_W-2:0], fits};
   end

endmodule

>>> rtl/core/rbmj_div_step.sv
// One quotient bit of a restoring divider with a shifted divisor.
module rbmj_div_step #(
   parameter int NUM_W = 31,
   parameter int DEN_W = 17,
   parameter int QUO_W = 15,
   parameter int BIT   = 0
) (
   input  logic [NUM_W-1:0] rem_i,
   input  logic [DEN_W-1:0] den_i,
   output logic [NUM_W-1:0] rem_o,
   output logic             bit_o
);

   localparam int TW = DEN_W + QUO_W;

   logic [TW-1:0] den_sh;
   logic [TW-1:0] rem_ext;

   // Subtract the divisor weighted by this quotient bit when it fits.
   always_comb begin
      den_sh  = TW'(den_i) << BIT;
      rem_ext = TW'(rem_i);
      bit_o   = (rem_ext >= den_sh);
      if (bit_o) begin
         rem_o = NUM_W'(rem_ext - den_sh);
      end else begin
         rem_o = rem_i;
      end
   end

endmodule

>>> rtl/core/range_bearing_measurement_jacobian.sv
// The path from request transfer to response valid is set, at COORD_BITS = 16, by
// the square root followed by the range dividers.
// Throughput: one item per clock while the skid is empty; a one-entry skid behind
// the output register lets the pipeline keep moving while a response waits, until it fills.
// Reset clears the stage valid bits, the output and the skid; no data is cleared.
// The block holds no state between items.
module range_bearing_measurement_jacobian #(
   parameter int COORD_BITS = rbmj_pkg::COORD_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   rbmj_req_if.sink   req,
   rbmj_rsp_if.source rsp
);

   localparam int FW   = rbmj_pkg::COORD_FIELD_W;
   localparam int CB   = COORD_BITS;
   localparam int EXT  = (CB > FW) ? CB : FW;
   localparam int AW   = (CB < FW) ? CB : FW;
   localparam int RW   = AW + 1;
   localparam int SW   = 2 * AW + 1;
   localparam int QR   = rbmj_pkg::RGRAD_FRAC + 1;
   localparam int QB   = rbmj_pkg::BGRAD_FRAC + 1;
   localparam int RNW  = AW + rbmj_pkg::RGRAD_FRAC + 1;
   localparam int BNW  = AW + rbmj_pkg::BGRAD_FRAC + 1;
   localparam int CW   = rbmj_pkg::CORDIC_W;
   localparam int ZW   = rbmj_pkg::ANG_ACC_W;
   localparam int NW   = rbmj_pkg::NORM_W;
   localparam int NSW  = $clog2(NW);
   localparam int PW   = $clog2(AW);

   // Stage numbers of each unit.
   localparam int SQ0   = 3;
   localparam int SQEND = 2 + RW;
   localparam int RRND  = 3 + RW;
   localparam int RNUM  = 4 + RW;
   localparam int REND  = RNUM + QR;
   localparam int BNUM  = 3;
   localparam int BEND  = BNUM + QB;
   localparam int CEND  = rbmj_pkg::CORDIC_STEPS + 1;
   localparam int CFIN  = CEND + 1;
   localparam int LAST0 = (REND > BEND) ? REND : BEND;
   localparam int LAST  = (LAST0 > CFIN) ? LAST0 : CFIN;

   typedef struct packed {
      logic                              zero;
      logic                              negx;
      logic                              negy;
      logic [rbmj_pkg::ANGLE_W-1:0]      head;
   } tag_type;

   typedef struct packed {
      logic        [rbmj_pkg::RANGE_W-1:0] expected_range;
      logic signed [rbmj_pkg::ANGLE_W-1:0] expected_bearing;
      logic signed [rbmj_pkg::RGRAD_W-1:0] range_grad_x;
      logic signed [rbmj_pkg::RGRAD_W-1:0] range_grad_y;
      logic signed [rbmj_pkg::BGRAD_W-1:0] bearing_grad_x;
      logic signed [rbmj_pkg::BGRAD_W-1:0] bearing_grad_y;
      logic                                zero_range;
   } rsp_data_type;

   logic             stage_en;
   logic [LAST:0]    v_ff;

   tag_type          tag_ff   [0:LAST];
   logic [AW-1:0]    ax_ff    [0:RNUM-1];
   logic [AW-1:0]    ay_ff    [0:RNUM-1];
   logic [2*AW-1:0]  sx_ff;
   logic [2*AW-1:0]  sy_ff;
   logic [SW-1:0]    lo_ff    [2:BEND-1];
   logic [RW:0]      sr_rem_ff  [SQ0:SQEND];
   logic [RW-1:0]    sr_root_ff [SQ0:SQEND];
   logic [RW-1:0]    rng_ff   [RRND:LAST];
   logic [RNW-1:0]   rrx_ff   [RNUM:REND-1];
   logic [RNW-1:0]   rry_ff   [RNUM:REND-1];
   logic [QR-1:0]    rqx_ff   [RNUM+1:LAST];
   logic [QR-1:0]    rqy_ff   [RNUM+1:LAST];
   logic [BNW-1:0]   bnx_ff   [BNUM:BEND-1];
   logic [BNW-1:0]   bny_ff   [BNUM:BEND-1];
   logic [QB-1:0]    bqx_ff   [BNUM+1:LAST];
   logic [QB-1:0]    bqy_ff   [BNUM+1:LAST];
   logic signed [CW-1:0] cx_ff [1:CEND-1];
   logic signed [CW-1:0] cy_ff [1:CEND-1];
   logic [ZW-1:0]    cz_ff    [2:CEND];
   logic [rbmj_pkg::ANGLE_W-1:0] ang_ff [CFIN:LAST];

   rsp_data_type     out_ff;
   rsp_data_type     sk_ff;
   rsp_data_type     out_in;
   logic             out_v_ff;
   logic             sk_v_ff;

   // The pipeline moves as one while the skid is empty.
   assign stage_en  = !sk_v_ff;
   assign req.ready = stage_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (stage_en) begin
         v_ff <= {v_ff[LAST-1:0], req.valid};
      end
   end

   // Stage 0: coordinate differences, magnitudes and signs.
   logic [EXT-1:0]     lx_ext, ly_ext, px_ext, py_ext;
   logic signed [CB:0] dx, dy, adx, ady;
   tag_type            tag_in;
   logic [AW-1:0]      ax_in, ay_in;

   always_comb begin
      lx_ext = EXT'($unsigned(req.landmark_x));
      ly_ext = EXT'($unsigned(req.landmark_y));
      px_ext = EXT'($unsigned(req.particle_x));
      py_ext = EXT'($unsigned(req.particle_y));
      dx = {lx_ext[CB-1], lx_ext[CB-1:0]} - {px_ext[CB-1], px_ext[CB-1:0]};
      dy = {ly_ext[CB-1], ly_ext[CB-1:0]} - {py_ext[CB-1], py_ext[CB-1:0]};
      adx = dx[CB] ? -dx : dx;
      ady = dy[CB] ? -dy : dy;
      ax_in = adx[AW-1:0];
      ay_in = ady[AW-1:0];
      tag_in.zero = (ax_in == '0) && (ay_in == '0);
      tag_in.negx = dx[CB];
      tag_in.negy = dy[CB];
      tag_in.head = req.particle_heading;
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         tag_ff[0] <= tag_in;
         ax_ff[0]  <= ax_in;
         ay_ff[0]  <= ay_in;
      end
   end

   // Tags and magnitudes travel alongside the work.
   for (genvar k = 1; k <= LAST; k++) begin : g_tag
      always_ff @(posedge clock) begin
         if (stage_en) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   for (genvar k = 1; k < RNUM; k++) begin : g_mag
      always_ff @(posedge clock) begin
         if (stage_en) begin
            ax_ff[k] <= ax_ff[k-1];
            ay_ff[k] <= ay_ff[k-1];
         end
      end
   end

   // Stage 1: squares, and normalization of the larger magnitude for the CORDIC.
   logic [AW-1:0]  mx;
   logic [PW-1:0]  msb;
   logic [NSW-1:0] nsh;
   logic [NW-1:0]  xn_in, yn_in;

   always_comb begin
      mx  = (ax_ff[0] > ay_ff[0]) ? ax_ff[0] : ay_ff[0];
      msb = '0;
      for (int b = 0; b < AW; b++) begin
         if (mx[b]) begin
            msb = PW'(b);
         end
      end
      nsh   = NSW'(NW - 1) - NSW'(msb);
      xn_in = NW'(ax_ff[0]) << nsh;
      yn_in = NW'(ay_ff[0]) << nsh;
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         sx_ff    <= {{AW{1'b0}}, ax_ff[0]} * {{AW{1'b0}}, ax_ff[0]};
         sy_ff    <= {{AW{1'b0}}, ay_ff[0]} * {{AW{1'b0}}, ay_ff[0]};
         cx_ff[1] <= CW'(xn_in);
         cy_ff[1] <= CW'(yn_in);
      end
   end

   // Stage 2: squared distance, carried on as radicand and divisor.
   always_ff @(posedge clock) begin
      if (stage_en) begin
         lo_ff[2] <= SW'(sx_ff) + SW'(sy_ff);
      end
   end

   for (genvar k = 3; k < BEND; k++) begin : g_lo
      always_ff @(posedge clock) begin
         if (stage_en) begin
            lo_ff[k] <= lo_ff[k-1];
         end
      end
   end

   // Square root, one root bit per stage from the top pair down.
   for (genvar k = SQ0; k <= SQEND; k++) begin : g_sqrt
      localparam int PI = RW - 1 - (k - SQ0);
      logic [2*RW-1:0] lo_pad;
      logic [RW:0]     rem_prev;
      logic [RW-1:0]   root_prev;
      logic [RW:0]     rem_in;
      logic [RW-1:0]   root_in;

      assign lo_pad = {1'b0, lo_ff[k-1]};
      if (k == SQ0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = sr_rem_ff[k-1];
         assign root_prev = sr_root_ff[k-1];
      end

      rbmj_sqrt_step #(.ROOT_W(RW)) u_step (
         .rem_i  (rem_prev),
         .root_i (root_prev),
         .pair_i (lo_pad[2*PI+1:2*PI]),
         .rem_o  (rem_in),
         .root_o (root_in)
      );

      always_ff @(posedge clock) begin
         if (stage_en) begin
            sr_rem_ff[k]  <= rem_in;
            sr_root_ff[k] <= root_in;
         end
      end
   end

   // Round the root to nearest: a remainder above the root means the upper neighbor.
   always_ff @(posedge clock) begin
      if (stage_en) begin
         if (sr_rem_ff[SQEND] > {1'b0, sr_root_ff[SQEND]}) begin
            rng_ff[RRND] <= sr_root_ff[SQEND] + RW'(1);
         end else begin
            rng_ff[RRND] <= sr_root_ff[SQEND];
         end
      end
   end

   for (genvar k = RRND + 1; k <= LAST; k++) begin : g_rng
      always_ff @(posedge clock) begin
         if (stage_en) begin
            rng_ff[k] <= rng_ff[k-1];
         end
      end
   end

   // Range gradient numerators with the half-divisor rounding term.
   always_ff @(posedge clock) begin
      if (stage_en) begin
         rrx_ff[RNUM] <= (RNW'(ax_ff[RNUM-1]) << rbmj_pkg::RGRAD_FRAC)
                         + RNW'(rng_ff[RNUM-1] >> 1);
         rry_ff[RNUM] <= (RNW'(ay_ff[RNUM-1]) << rbmj_pkg::RGRAD_FRAC)
                         + RNW'(rng_ff[RNUM-1] >> 1);
      end
   end

   // Range gradient division by the rounded range, one quotient bit per stage.
   for (genvar k = RNUM + 1; k <= LAST; k++) begin : g_rdiv
      if (k <= REND) begin : g_step
         localparam int J = REND - k;
         logic [RNW-1:0] remx_in, remy_in;
         logic           bitx, bity;
         logic [QR-1:0]  qx_prev, qy_prev;

         rbmj_div_step #(.NUM_W(RNW), .DEN_W(RW), .QUO_W(QR), .BIT(J)) u_divx (
            .rem_i (rrx_ff[k-1]), .den_i (rng_ff[k-1]), .rem_o (remx_in), .bit_o (bitx)
         );
         rbmj_div_step #(.NUM_W(RNW), .DEN_W(RW), .QUO_W(QR), .BIT(J)) u_divy (
            .rem_i (rry_ff[k-1]), .den_i (rng_ff[k-1]), .rem_o (remy_in), .bit_o (bity)
         );

         if (k == RNUM + 1) begin : g_first
            assign qx_prev = '0;
            assign qy_prev = '0;
         end else begin : g_next
            assign qx_prev = rqx_ff[k-1];
            assign qy_prev = rqy_ff[k-1];
         end

         if (k < REND) begin : g_rem
            always_ff @(posedge clock) begin
               if (stage_en) begin
                  rrx_ff[k] <= remx_in;
                  rry_ff[k] <= remy_in;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (stage_en) begin
               rqx_ff[k] <= qx_prev | (QR'(bitx) << J);
               rqy_ff[k] <= qy_prev | (QR'(bity) << J);
            end
         end
      end else begin : g_hold
         always_ff @(posedge clock) begin
            if (stage_en) begin
               rqx_ff[k] <= rqx_ff[k-1];
               rqy_ff[k] <= rqy_ff[k-1];
            end
         end
      end
   end

   // Bearing gradient numerators: the x entry uses dy, the y entry uses dx.
   always_ff @(posedge clock) begin
      if (stage_en) begin
         bnx_ff[BNUM] <= (BNW'(ay_ff[BNUM-1]) << rbmj_pkg::BGRAD_FRAC)
                         + BNW'(lo_ff[BNUM-1] >> 1);
         bny_ff[BNUM] <= (BNW'(ax_ff[BNUM-1]) << rbmj_pkg::BGRAD_FRAC)
                         + BNW'(lo_ff[BNUM-1] >> 1);
      end
   end

   // Bearing gradient division by the squared distance.
   for (genvar k = BNUM + 1; k <= LAST; k++) begin : g_bdiv
      if (k <= BEND) begin : g_step
         localparam int J = BEND - k;
         logic [BNW-1:0] remx_in, remy_in;
         logic           bitx, bity;
         logic [QB-1:0]  qx_prev, qy_prev;

         rbmj_div_step #(.NUM_W(BNW), .DEN_W(SW), .QUO_W(QB), .BIT(J)) u_divx (
            .rem_i (bnx_ff[k-1]), .den_i (lo_ff[k-1]), .rem_o (remx_in), .bit_o (bitx)
         );
         rbmj_div_step #(.NUM_W(BNW), .DEN_W(SW), .QUO_W(QB), .BIT(J)) u_divy (
            .rem_i (bny_ff[k-1]), .den_i (lo_ff[k-1]), .rem_o (remy_in), .bit_o (bity)
         );

         if (k == BNUM + 1) begin : g_first
            assign qx_prev = '0;
            assign qy_prev = '0;
         end else begin : g_next
            assign qx_prev = bqx_ff[k-1];
            assign qy_prev = bqy_ff[k-1];
         end

         if (k < BEND) begin : g_rem
            always_ff @(posedge clock) begin
               if (stage_en) begin
                  bnx_ff[k] <= remx_in;
                  bny_ff[k] <= remy_in;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (stage_en) begin
               bqx_ff[k] <= qx_prev | (QB'(bitx) << J);
               bqy_ff[k] <= qy_prev | (QB'(bity) << J);
            end
         end
      end else begin : g_hold
         always_ff @(posedge clock) begin
            if (stage_en) begin
               bqx_ff[k] <= bqx_ff[k-1];
               bqy_ff[k] <= bqy_ff[k-1];
            end
         end
      end
   end

   // CORDIC vectoring, one rotation per stage.
   for (genvar k = 2; k <= CEND; k++) begin : g_cordic
      logic signed [CW-1:0] x_in, y_in;
      logic [ZW-1:0]        z_prev, z_in;

      if (k == 2) begin : g_first
         assign z_prev = '0;
      end else begin : g_next
         assign z_prev = cz_ff[k-1];
      end

      rbmj_cordic_step #(.STEP(k - 2)) u_step (
         .x_i (cx_ff[k-1]), .y_i (cy_ff[k-1]), .z_i (z_prev),
         .x_o (x_in), .y_o (y_in), .z_o (z_in)
      );

      if (k < CEND) begin : g_xy
         always_ff @(posedge clock) begin
            if (stage_en) begin
               cx_ff[k] <= x_in;
               cy_ff[k] <= y_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en) begin
            cz_ff[k] <= z_in;
         end
      end
   end

   // Quadrant mapping, heading subtraction and rounding to the bearing field.
   logic [ZW-1:0] ang_full;

   always_comb begin
      ang_full = tag_ff[CEND].zero ? '0 : cz_ff[CEND];
      if (tag_ff[CEND].negx) begin
         ang_full = rbmj_pkg::ANGLE_PI - ang_full;
      end
      if (tag_ff[CEND].negy) begin
         ang_full = -ang_full;
      end
      ang_full = ang_full - {tag_ff[CEND].head, 16'h0000} + rbmj_pkg::ANGLE_HALF;
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         ang_ff[CFIN] <= ang_full[ZW-1:ZW-rbmj_pkg::ANGLE_W];
      end
   end

   for (genvar k = CFIN + 1; k <= LAST; k++) begin : g_ang
      always_ff @(posedge clock) begin
         if (stage_en) begin
            ang_ff[k] <= ang_ff[k-1];
         end
      end
   end

   // Result assembly: signs applied, range and gradients forced to zero
   // for coincident points.
   logic [rbmj_pkg::RGRAD_W-1:0] rgx_mag, rgy_mag;
   logic [rbmj_pkg::BGRAD_W-1:0] bgx_mag, bgy_mag;

   always_comb begin
      rgx_mag = rbmj_pkg::RGRAD_W'(rqx_ff[LAST]);
      rgy_mag = rbmj_pkg::RGRAD_W'(rqy_ff[LAST]);
      bgx_mag = rbmj_pkg::BGRAD_W'(bqx_ff[LAST]);
      bgy_mag = rbmj_pkg::BGRAD_W'(bqy_ff[LAST]);
      out_in.zero_range       = tag_ff[LAST].zero;
      out_in.expected_bearing = ang_ff[LAST];
      if (tag_ff[LAST].zero) begin
         out_in.expected_range = '0;
         out_in.range_grad_x   = '0;
         out_in.range_grad_y   = '0;
         out_in.bearing_grad_x = '0;
         out_in.bearing_grad_y = '0;
      end else begin
         out_in.expected_range = rbmj_pkg::RANGE_W'(rng_ff[LAST]);
         out_in.range_grad_x   = tag_ff[LAST].negx ? -rgx_mag : rgx_mag;
         out_in.range_grad_y   = tag_ff[LAST].negy ? -rgy_mag : rgy_mag;
         out_in.bearing_grad_x = tag_ff[LAST].negy ? bgx_mag : -bgx_mag;
         out_in.bearing_grad_y = tag_ff[LAST].negx ? -bgy_mag : bgy_mag;
      end
   end

   // Output register with a one-entry skid behind it.
   logic out_free;
   logic push;

   assign out_free = !out_v_ff || rsp.ready;
   assign push     = stage_en && v_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else if (out_free) begin
         if (sk_v_ff) begin
            out_v_ff <= 1'b1;
            sk_v_ff  <= 1'b0;
         end else begin
            out_v_ff <= push;
         end
      end else if (push) begin
         sk_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (sk_v_ff) begin
            out_ff <= sk_ff;
         end else if (push) begin
            out_ff <= out_in;
         end
      end else if (push) begin
         sk_ff <= out_in;
      end
   end

   assign rsp.valid            = out_v_ff;
   assign rsp.expected_range   = out_ff.expected_range;
   assign rsp.expected_bearing = out_ff.expected_bearing;
   assign rsp.range_grad_x     = out_ff.range_grad_x;
   assign rsp.range_grad_y     = out_ff.range_grad_y;
   assign rsp.bearing_grad_x   = out_ff.bearing_grad_x;
   assign rsp.bearing_grad_y   = out_ff.bearing_grad_y;
   assign rsp.zero_range       = out_ff.zero_range;

   // The skid only fills behind a stalled output.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      sk_v_ff |-> out_v_ff)
      else $error("skid holds a transfer while the output register is empty");

   // Coincident points give zero range and zero gradients.
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_ff.zero_range) |-> (out_ff.expected_range == '0
         && out_ff.range_grad_x == '0 && out_ff.range_grad_y == '0
         && out_ff.bearing_grad_x == '0 && out_ff.bearing_grad_y == '0))
      else $error("zero range result carries nonzero fields");

   // Distinct points never round to a zero range.
   a_range_nonzero: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !out_ff.zero_range) |-> (out_ff.expected_range != '0))
      else $error("nonzero offset produced a zero range");

endmodule
